>>> rtl/multi_button_debounce_edge_latch_assert.svh
// Assertion macros shared by the debouncer modules.
`ifndef MULTI_BUTTON_DEBOUNCE_EDGE_LATCH_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCE_EDGE_LATCH_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MBDEL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MBDEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mbdel_pkg.sv
package mbdel_pkg;

  // Number of buttons handled in parallel.
  localparam int unsigned ButtonW = 32;

  // Default length of the sample window.
  localparam int unsigned DepthDefault = 8;

  // All buttons pressed: the start value of the window AND.
  localparam logic [ButtonW-1:0] AllPressed = 32'hFFFF_FFFF;

  // Command codes.
  localparam logic CmdSample = 1'b0;
  localparam logic CmdStatus = 1'b1;

  // One step handed from the input register to the core.
  typedef struct packed {
    logic valid;
    logic cmd;
  } step_t;

endpackage

>>> rtl/mbdel_in_if.sv
// Command channel: one command with its sample and mask per transfer.
interface mbdel_in_if
  import mbdel_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               command;
  logic [ButtonW-1:0] raw_sample;
  logic [ButtonW-1:0] select_mask;

  modport source (output valid, output command, output raw_sample, output select_mask,
                  input ready);
  modport sink   (input valid, input command, input raw_sample, input select_mask,
                  output ready);
endinterface

>>> rtl/mbdel_out_if.sv
// Result channel: the masked press flags of one status command per transfer.
interface mbdel_out_if
  import mbdel_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ButtonW-1:0] pressed_bits;

  modport source (output valid, output pressed_bits, input ready);
  modport sink   (input valid, input pressed_bits, output ready);
endinterface

>>> rtl/mbdel_core.sv
`include "multi_button_debounce_edge_latch_assert.svh"

module mbdel_core
  import mbdel_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  step_t              step_i,
  input  logic [ButtonW-1:0] raw_i,
  input  logic [ButtonW-1:0] mask_i,
  output logic [ButtonW-1:0] hit_o
);

  localparam int unsigned SlotW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(DEPTH - 1);

  logic [ButtonW-1:0] hist_q [DEPTH];
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [ButtonW-1:0] level_q, level_d;
  logic [ButtonW-1:0] press_q, press_d;
  logic               do_sample, do_status;

  assign do_sample = step_i.valid && (step_i.cmd == CmdSample);
  assign do_status = step_i.valid && (step_i.cmd == CmdStatus);

  // Flags selected by the status mask, taken before the clear.
  assign hit_o = press_q & mask_i;

  // Window AND with the new sample already in its slot.
  always_comb begin
    level_d = AllPressed;
    for (int k = 0; k < DEPTH; k++) begin
      if (SlotW'(k) == slot_q) begin
        level_d = level_d & raw_i;
      end else begin
        level_d = level_d & hist_q[k];
      end
    end
  end

  // Ring pointer wraps after the last slot.
  assign slot_d = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);

  // A sample sets flags on rising levels; a status command clears what it read.
  always_comb begin
    press_d = press_q;
    if (do_sample) begin
      press_d = press_q | (level_d & ~level_q);
    end else if (do_status) begin
      press_d = press_q & ~hit_o;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      level_q <= '0;
      press_q <= '0;
    end else begin
      press_q <= press_d;
      if (do_sample) begin
        slot_q  <= slot_d;
        level_q <= level_d;
      end
    end
  end

  // Sample history; it starts all zero so a fresh press needs a full window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        hist_q[k] <= '0;
      end
    end else if (do_sample) begin
      hist_q[slot_q] <= raw_i;
    end
  end

  `MBDEL_ASSERT_NEXT(a_status_clears, do_status, (press_q & $past(mask_i)) == '0, "selected flags not cleared")
  `MBDEL_ASSERT_NEXT(a_level_in_sample, do_sample, (level_q & ~$past(raw_i)) == '0, "level set without newest sample")
  `MBDEL_ASSERT_NEXT(a_idle_holds, !step_i.valid, $stable(slot_q) && $stable(level_q) && $stable(press_q), "state moved without a step")

endmodule

>>> rtl/multi_button_debounce_edge_latch.sv
// Debouncer for 32 buttons with sticky press flags. A sample command stores one raw
// reading in a window of the last DEPTH readings; a button's level is high only when
// every reading in the window shows it pressed, and each rise of a level sets its
// press flag. A status command returns the flags under its mask and clears them.
// Rate: one command per clock cycle while no status command is stalled. A command passes
// an input register, the window logic and, for a status command, an output register,
// from which its result is presented. A status command waits in the input register
// only while the output register still holds a result that has not been taken.
`include "multi_button_debounce_edge_latch_assert.svh"

module multi_button_debounce_edge_latch
  import mbdel_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mbdel_in_if.sink    cmd_i,
  mbdel_out_if.source res_o
);

  logic               in_valid_q, in_valid_d;
  logic               cmd_q;
  logic [ButtonW-1:0] raw_q, mask_q;
  logic               out_valid_q, out_valid_d;
  logic [ButtonW-1:0] pressed_q;
  logic               out_free, advance, in_xfer;
  logic [ButtonW-1:0] hit;
  step_t              step;

  // The held command moves on when it needs no result slot or the slot is free.
  assign out_free = !out_valid_q || res_o.ready;
  assign advance  = in_valid_q && ((cmd_q == CmdSample) || out_free);
  assign cmd_i.ready = !in_valid_q || advance;
  assign in_xfer  = cmd_i.valid && cmd_i.ready;

  assign step.valid = advance;
  assign step.cmd   = cmd_q;

  mbdel_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .raw_i  (raw_q),
    .mask_i (mask_q),
    .hit_o  (hit)
  );

  // Valid flags of the input and output registers.
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && (cmd_q == CmdStatus)) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= cmd_i.command;
      raw_q  <= cmd_i.raw_sample;
      mask_q <= cmd_i.select_mask;
    end
    if (advance && (cmd_q == CmdStatus)) begin
      pressed_q <= hit;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.pressed_bits = pressed_q;

  `MBDEL_ASSERT_NEXT(a_status_waits, in_valid_q && (cmd_q == CmdStatus) && !out_free, in_valid_q && (cmd_q == CmdStatus), "stalled status command lost")
  `MBDEL_ASSERT_NOW(a_sample_never_stalls, in_valid_q && (cmd_q == CmdSample), cmd_i.ready, "sample command stalled")
  `MBDEL_ASSERT_NEXT(a_result_loaded, advance && (cmd_q == CmdStatus), out_valid_q, "status result not presented")

endmodule

>>> tb/sv/tb_multi_button_debounce_edge_latch.sv
`timescale 1ns / 100ps

module tb_multi_button_debounce_edge_latch
  import mbdel_pkg::*;
();

  // One command as the sender presents it, plus a request to hold it back until
  // every status result has been returned.
  typedef struct {
    logic               cmd;
    logic [ButtonW-1:0] raw;
    logic [ButtonW-1:0] mask;
    bit                 drain_first;
  } button_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mbdel_in_if  cmd_if ();
  mbdel_out_if res_if ();

  multi_button_debounce_edge_latch uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // Predicted state of the debouncer.
  logic [ButtonW-1:0] win_hist [DepthDefault];
  int unsigned        win_slot;
  logic [ButtonW-1:0] level_now;
  logic [ButtonW-1:0] press_flags;

  button_cmd_t        pending_cmds[$];
  logic [ButtonW-1:0] flags_due[$];
  button_cmd_t        cur_cmd;
  int unsigned        total_cmds;
  int unsigned        sent_cmds;
  int unsigned        error_count;
  int unsigned        gap_left;
  int unsigned        stall_left;
  int unsigned        src_gap_pct;
  int unsigned        snk_stall_pct;
  int unsigned        snk_cycle;
  bit                 calm_tail;

  always #5 clk_i = ~clk_i;

  task automatic log_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one accepted command to the predicted state; a status command yields
  // the flags it should return.
  task automatic debounce_step(input button_cmd_t c);
    logic [ButtonW-1:0] prior;
    logic [ButtonW-1:0] hit;
    if (c.cmd == CmdSample) begin
      prior = level_now;
      win_hist[win_slot] = c.raw;
      win_slot = (win_slot + 1) % DepthDefault;
      level_now = AllPressed;
      for (int k = 0; k < DepthDefault; k++) begin
        level_now &= win_hist[k];
      end
      press_flags |= level_now & ~prior;
    end else begin
      hit = press_flags & c.mask;
      press_flags &= ~hit;
      flags_due.push_back(hit);
    end
  endtask

  // The field that a command ignores is filled with random bits.
  task automatic push_sample(input logic [ButtonW-1:0] raw);
    button_cmd_t c;
    c.cmd = CmdSample;
    c.raw = raw;
    c.mask = $urandom;
    c.drain_first = 1'b0;
    pending_cmds.push_back(c);
  endtask

  task automatic push_status(input logic [ButtonW-1:0] mask, input bit drain);
    button_cmd_t c;
    c.cmd = CmdStatus;
    c.raw = $urandom;
    c.mask = mask;
    c.drain_first = drain;
    pending_cmds.push_back(c);
  endtask

  // Sender: presents queued commands, holds each until its transfer, and idles in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_valid;
    if (!rst_ni) begin
      cmd_if.valid       <= 1'b0;
      cmd_if.command     <= CmdSample;
      cmd_if.raw_sample  <= '0;
      cmd_if.select_mask <= '0;
      gap_left = 0;
      src_gap_pct = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        debounce_step(cur_cmd);
        sent_cmds++;
      end
      calm_tail = (pending_cmds.size() < 150);
      if (!(cmd_if.valid && !cmd_if.ready)) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          if (pending_cmds[0].drain_first && flags_due.size() != 0) begin
            // Hold back until the result side has caught up.
          end else if (!calm_tail && $urandom_range(99) < src_gap_pct) begin
            gap_left = $urandom_range(14, 1) - 1;
          end else begin
            cur_cmd = pending_cmds.pop_front();
            nxt_valid = 1'b1;
            // Change the idle density now and then, with stretches of none.
            if (pending_cmds.size() % 64 == 0) begin
              case ($urandom_range(2))
                0: src_gap_pct = 0;
                1: src_gap_pct = 5;
                default: src_gap_pct = 30;
              endcase
            end
          end
        end
        cmd_if.valid <= nxt_valid;
        if (nxt_valid) begin
          cmd_if.command     <= cur_cmd.cmd;
          cmd_if.raw_sample  <= cur_cmd.raw;
          cmd_if.select_mask <= cur_cmd.mask;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    logic               nxt_ready;
    logic [ButtonW-1:0] want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
      snk_stall_pct = 0;
      snk_cycle = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (flags_due.size() == 0) begin
          log_mismatch($sformatf("unexpected result, pressed_bits %h", res_if.pressed_bits));
        end else begin
          want = flags_due.pop_front();
          if (res_if.pressed_bits !== want) begin
            log_mismatch($sformatf("pressed_bits %h, want %h", res_if.pressed_bits, want));
          end
        end
      end
      snk_cycle++;
      if (snk_cycle % 97 == 0) begin
        case ($urandom_range(2))
          0: snk_stall_pct = 0;
          1: snk_stall_pct = 8;
          default: snk_stall_pct = 35;
        endcase
      end
      if (stall_left != 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!calm_tail && $urandom_range(99) < snk_stall_pct) begin
        stall_left = $urandom_range(14, 1) - 1;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      res_if.ready <= nxt_ready;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [ButtonW-1:0] held;
    logic [ButtonW-1:0] raw;
    logic [ButtonW-1:0] mask;
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = CmdSample;
    cmd_if.raw_sample  = '0;
    cmd_if.select_mask = '0;
    res_if.ready       = 1'b0;
    for (int k = 0; k < DepthDefault; k++) begin
      win_hist[k] = '0;
    end
    win_slot = 0;
    level_now = '0;
    press_flags = '0;
    sent_cmds = 0;
    error_count = 0;
    calm_tail = 1'b0;

    // Fresh after reset nothing is flagged, and a level needs a full window to rise.
    push_status(AllPressed, 1'b0);
    for (int k = 0; k < DepthDefault - 1; k++) begin
      push_sample(AllPressed);
    end
    push_status(AllPressed, 1'b0);
    push_sample(AllPressed);
    // An empty mask returns and clears nothing; then clear the odd-numbered flags.
    push_status('0, 1'b0);
    push_status(32'hAAAA_AAAA, 1'b0);
    push_sample(32'h0000_FFFF);
    // A second rise on top of flags still set, with the ring wrapping.
    for (int k = 0; k < DepthDefault; k++) begin
      push_sample(AllPressed);
    end
    push_status(AllPressed, 1'b1);
    push_sample('0);
    push_status(AllPressed, 1'b0);

    // Random part: buttons held with occasional bounce, plus noise and status reads.
    held = $urandom;
    for (int n = 0; n < 1700; n++) begin
      if (n % 300 == 299) begin
        push_status($urandom, 1'b1);
      end else if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0, 1: mask = AllPressed;
          2: mask = $urandom;
          default: mask = $urandom & $urandom;
        endcase
        push_status(mask, 1'b0);
      end else if ($urandom_range(99) < 8) begin
        push_sample($urandom);
      end else begin
        if ($urandom_range(99) < 10) begin
          held ^= $urandom & $urandom & $urandom;
        end
        raw = held;
        if ($urandom_range(99) < 30) begin
          raw ^= $urandom & $urandom & $urandom & $urandom;
        end
        push_sample(raw);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cmds != total_cmds) @(posedge clk_i);
    while (flags_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
